/* design/lfpm_pkg.sv */
`timescale 1ns / 1ps
// shared types, widths, register codes and reset values for the line follow pid motor mix
package lfpm_pkg;

  // payload and register widths
  localparam int POS_BITS       = 13;
  localparam int GAIN_BITS      = 16;
  localparam int SPEED_BITS     = 8;
  localparam int DUTY_BITS      = 8;
  localparam int ERR_BITS       = POS_BITS + 1;
  localparam int DER_BITS       = ERR_BITS + 1;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = GAIN_BITS;

  // magnitude limit on the integral before the ki multiply
  localparam int KI_MAG_LIMIT = 32;

  // parameter defaults
  localparam int GAIN_FRAC_BITS_DEF = 12;
  localparam int SUM_BITS_DEF       = 32;

  // register reset values
  localparam logic [GAIN_BITS-1:0]  KP_GAIN_RST    = 16'd328;
  localparam logic [GAIN_BITS-1:0]  KI_GAIN_RST    = 16'd0;
  localparam logic [GAIN_BITS-1:0]  KD_GAIN_RST    = 16'd0;
  localparam logic [POS_BITS-1:0]   TARGET_POS_RST = 13'd3500;
  localparam logic [SPEED_BITS-1:0] BASE_SPEED_RST = 8'd70;
  localparam logic [SPEED_BITS-1:0] MAX_SPEED_RST  = 8'd90;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_KP_GAIN         = 3'd0,
    REG_KI_GAIN         = 3'd1,
    REG_KD_GAIN         = 3'd2,
    REG_TARGET_POSITION = 3'd3,
    REG_BASE_SPEED      = 3'd4,
    REG_MAX_SPEED       = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic                 forward;
    logic [DUTY_BITS-1:0] duty;
  } wheel_out_t;

endpackage

/* design/lfpm_channels.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for position samples and wheel commands

interface lfpm_sample_if;
  import lfpm_pkg::*;

  logic                valid;
  logic                ready;
  logic [POS_BITS-1:0] line_position;

  modport source (output valid, output line_position, input ready);
  modport sink   (input valid, input line_position, output ready);
endinterface

interface lfpm_result_if;
  import lfpm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 left_forward;
  logic [DUTY_BITS-1:0] left_duty;
  logic                 right_forward;
  logic [DUTY_BITS-1:0] right_duty;

  modport source (output valid, output left_forward, output left_duty,
                  output right_forward, output right_duty, input ready);
  modport sink   (input valid, input left_forward, input left_duty,
                  input right_forward, input right_duty, output ready);
endinterface

/* design/line_follow_pid_motor_mix.sv */
`timescale 1ns / 1ps
// pid steering controller with differential wheel mix, top level
//
// Takes one line position sample per beat and returns one wheel command beat
// per sample. error = target_position - line_position feeds a saturating
// integral and a derivative against the previous error; the drive
// kp*e + ki*sum + kd*d (gains unsigned with GAIN_FRAC_BITS fraction bits) is
// added to base_speed for the left wheel and subtracted for the right. Each
// wheel speed is truncated toward zero, clamped to +-max_speed and split into
// a direction bit (1 forward, also at zero speed) and an 8-bit duty.
// Throughput is one sample per clock while results are taken; a sample's
// result is offered after it passes the five register stages: error and integral
// (loaded at the accepting edge), gain multiplies, drive sum, wheel mix, and
// the output register. The integral and previous error are updated in the
// accept cycle itself, so samples may follow back to back. Each stage holds
// its beat while the next is full, so the block keeps taking samples while a
// result waits until all five stages are occupied. Write configuration only
// while no sample is in flight.
module line_follow_pid_motor_mix #(
  parameter int GAIN_FRAC_BITS = lfpm_pkg::GAIN_FRAC_BITS_DEF,
  parameter int SUM_BITS       = lfpm_pkg::SUM_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lfpm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lfpm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  lfpm_sample_if.sink                         sample,
  lfpm_result_if.source                       result
);
  import lfpm_pkg::*;

  // integral magnitude is capped before the multiply; any larger ki term
  // already pins both wheels to the speed clamp
  localparam int KI_MAG_BITS  = (SUM_BITS < KI_MAG_LIMIT) ? SUM_BITS : KI_MAG_LIMIT;
  localparam int KI_PROD_BITS = KI_MAG_BITS + GAIN_BITS;
  localparam int KI_TERM_BITS = KI_PROD_BITS + 1;
  localparam int KP_TERM_BITS = GAIN_BITS + 1 + ERR_BITS;
  localparam int KD_TERM_BITS = GAIN_BITS + 1 + DER_BITS;
  localparam int DRIVE_BITS   =
    ((KI_TERM_BITS > KD_TERM_BITS) ? KI_TERM_BITS : KD_TERM_BITS) + 2;
  localparam int BASE_BITS    = SPEED_BITS + GAIN_FRAC_BITS;
  localparam int WHEEL_BITS   =
    ((DRIVE_BITS > BASE_BITS) ? DRIVE_BITS : BASE_BITS) + 2;

  // configuration registers
  logic [GAIN_BITS-1:0]  kp_gain;
  logic [GAIN_BITS-1:0]  ki_gain;
  logic [GAIN_BITS-1:0]  kd_gain;
  logic [POS_BITS-1:0]   target_position;
  logic [SPEED_BITS-1:0] base_speed;
  logic [SPEED_BITS-1:0] max_speed;

  // controller state
  logic [SUM_BITS-1:0]        error_sum;
  logic signed [ERR_BITS-1:0] previous_error;

  // stage valids and advance enables
  logic a_valid, b_valid, c_valid, d_valid, o_valid;
  logic a_en, b_en, c_en, d_en, o_en;
  logic take;

  // stage payloads
  logic signed [ERR_BITS-1:0]     a_err;
  logic signed [DER_BITS-1:0]     a_der;
  logic [SUM_BITS-1:0]            a_sum;
  logic signed [KP_TERM_BITS-1:0] b_kp_term;
  logic signed [KD_TERM_BITS-1:0] b_kd_term;
  logic [KI_PROD_BITS-1:0]        b_ki_prod;
  logic                           b_ki_neg;
  logic signed [DRIVE_BITS-1:0]   c_drive;
  logic signed [WHEEL_BITS-1:0]   d_left;
  logic signed [WHEEL_BITS-1:0]   d_right;

  // accept-cycle arithmetic
  logic signed [ERR_BITS-1:0] err;
  logic signed [DER_BITS-1:0] der;
  logic [SUM_BITS:0]          sum_wide;
  logic [SUM_BITS-1:0]        error_sum_next;

  logic [SUM_BITS-1:0]          sum_mag;
  logic [KI_MAG_BITS-1:0]       ki_mag;
  logic signed [KI_TERM_BITS-1:0] ki_term;
  logic signed [WHEEL_BITS-1:0] base_fixed;
  wheel_out_t                   left_cmd;
  wheel_out_t                   right_cmd;

  // ---------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain         <= KP_GAIN_RST;
      ki_gain         <= KI_GAIN_RST;
      kd_gain         <= KD_GAIN_RST;
      target_position <= TARGET_POS_RST;
      base_speed      <= BASE_SPEED_RST;
      max_speed       <= MAX_SPEED_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KP_GAIN:         kp_gain         <= cfg_data[GAIN_BITS-1:0];
        REG_KI_GAIN:         ki_gain         <= cfg_data[GAIN_BITS-1:0];
        REG_KD_GAIN:         kd_gain         <= cfg_data[GAIN_BITS-1:0];
        REG_TARGET_POSITION: target_position <= cfg_data[POS_BITS-1:0];
        REG_BASE_SPEED:      base_speed      <= cfg_data[SPEED_BITS-1:0];
        REG_MAX_SPEED:       max_speed       <= cfg_data[SPEED_BITS-1:0];
        default: ;  // writes to unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // flow control: a stage loads when it is empty or the next one loads
  // ---------------------------------------------------------------------
  assign o_en = !o_valid || result.ready;
  assign d_en = !d_valid || o_en;
  assign c_en = !c_valid || d_en;
  assign b_en = !b_valid || c_en;
  assign a_en = !a_valid || b_en;

  assign sample.ready = a_en;
  assign take         = sample.valid && a_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (a_en) a_valid <= sample.valid;
      if (b_en) b_valid <= a_valid;
      if (c_en) c_valid <= b_valid;
      if (d_en) d_valid <= c_valid;
      if (o_en) o_valid <= d_valid;
    end
  end

  // ---------------------------------------------------------------------
  // stage a: error, derivative and saturating integral
  // ---------------------------------------------------------------------
  assign err = $signed({1'b0, target_position}) - $signed({1'b0, sample.line_position});
  assign der = DER_BITS'(err) - DER_BITS'(previous_error);

  // one guard bit catches overflow; clamp to the signed limits
  assign sum_wide = {error_sum[SUM_BITS-1], error_sum}
                  + {{(SUM_BITS + 1 - ERR_BITS){err[ERR_BITS-1]}}, err};

  always_comb begin
    if (sum_wide[SUM_BITS] == sum_wide[SUM_BITS-1]) begin
      error_sum_next = sum_wide[SUM_BITS-1:0];
    end else if (sum_wide[SUM_BITS]) begin
      error_sum_next = {1'b1, {(SUM_BITS - 1){1'b0}}};
    end else begin
      error_sum_next = {1'b0, {(SUM_BITS - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
    end else if (take) begin
      error_sum      <= error_sum_next;
      previous_error <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_err <= err;
      a_der <= der;
      a_sum <= error_sum_next;
    end
  end

  // ---------------------------------------------------------------------
  // stage b: the three gain multiplies, ki on sign and magnitude
  // ---------------------------------------------------------------------
  assign sum_mag = a_sum[SUM_BITS-1] ? (~a_sum + SUM_BITS'(1)) : a_sum;

  generate
    if (SUM_BITS > KI_MAG_BITS) begin : g_ki_cap
      assign ki_mag = (|sum_mag[SUM_BITS-1:KI_MAG_BITS]) ? {KI_MAG_BITS{1'b1}}
                                                         : sum_mag[KI_MAG_BITS-1:0];
    end else begin : g_ki_full
      assign ki_mag = sum_mag;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (b_en && a_valid) begin
      b_kp_term <= KP_TERM_BITS'($signed({1'b0, kp_gain})) * KP_TERM_BITS'(a_err);
      b_kd_term <= KD_TERM_BITS'($signed({1'b0, kd_gain})) * KD_TERM_BITS'(a_der);
      b_ki_prod <= KI_PROD_BITS'(ki_mag) * KI_PROD_BITS'(ki_gain);
      b_ki_neg  <= a_sum[SUM_BITS-1];
    end
  end

  // ---------------------------------------------------------------------
  // stage c: drive sum
  // ---------------------------------------------------------------------
  assign ki_term = b_ki_neg ? -$signed({1'b0, b_ki_prod}) : $signed({1'b0, b_ki_prod});

  always_ff @(posedge clk) begin
    if (c_en && b_valid) begin
      c_drive <= DRIVE_BITS'(b_kp_term) + DRIVE_BITS'(b_kd_term) + DRIVE_BITS'(ki_term);
    end
  end

  // ---------------------------------------------------------------------
  // stage d: differential mix around the base speed
  // ---------------------------------------------------------------------
  assign base_fixed = $signed(WHEEL_BITS'({base_speed, {GAIN_FRAC_BITS{1'b0}}}));

  always_ff @(posedge clk) begin
    if (d_en && c_valid) begin
      d_left  <= base_fixed + WHEEL_BITS'(c_drive);
      d_right <= base_fixed - WHEEL_BITS'(c_drive);
    end
  end

  // ---------------------------------------------------------------------
  // output stage: truncate toward zero, clamp, split into direction and duty
  // ---------------------------------------------------------------------
  function automatic wheel_out_t wheel_split(input logic signed [WHEEL_BITS-1:0] speed,
                                             input logic [SPEED_BITS-1:0] limit);
    logic [WHEEL_BITS-1:0] mag;
    logic [WHEEL_BITS-1:0] whole;
    wheel_out_t            cmd;
    mag   = speed[WHEEL_BITS-1] ? (~speed + WHEEL_BITS'(1)) : speed;
    whole = mag >> GAIN_FRAC_BITS;
    if (whole > WHEEL_BITS'(limit)) begin
      cmd.duty = DUTY_BITS'(limit);
    end else begin
      cmd.duty = whole[DUTY_BITS-1:0];
    end
    // zero speed reads as forward
    cmd.forward = !(speed[WHEEL_BITS-1] && (cmd.duty != '0));
    return cmd;
  endfunction

  assign left_cmd  = wheel_split(d_left, max_speed);
  assign right_cmd = wheel_split(d_right, max_speed);

  assign result.valid = o_valid;

  always_ff @(posedge clk) begin
    if (o_en && d_valid) begin
      result.left_forward  <= left_cmd.forward;
      result.left_duty     <= left_cmd.duty;
      result.right_forward <= right_cmd.forward;
      result.right_duty    <= right_cmd.duty;
    end
  end

endmodule
